@@ hdl/iexp_pkg.sv @@
`default_nettype none

package iexp_pkg;

    // Input draw width and derived stream widths
    localparam int RANDOM_BITS = 24;
    localparam int LOGIT_W     = 32;
    localparam int EXP_W       = 31;
    localparam int S_TDATA_W   = ((LOGIT_W + RANDOM_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((EXP_W + 7) / 8) * 8;

    // Divider geometry: quotient bits, remainder bits, steps per stage
    localparam int DIV_W      = 32;
    localparam int REM_W      = 30;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = DIV_W / DIV_STEPS;

    // Shift cap and saturation
    localparam logic [4:0]       MAX_SHIFT = 5'd31;
    localparam logic [EXP_W-1:0] SAT31     = {EXP_W{1'b1}};
    // Largest magnitude whose square stays at or below 2^31-1
    localparam logic [33:0]      SQRT_SAT  = 34'd46340;

    // Config register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LN2    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_C      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd4;

    // Rounding modes
    localparam logic [1:0] RND_TRUNC = 2'd0;
    localparam logic [1:0] RND_HALF  = 2'd1;
    localparam logic [1:0] RND_STOCH = 2'd2;

    // Side data that rides along with each word
    typedef struct packed {
        logic                   zero;
        logic [RANDOM_BITS-1:0] rf;
    } tag_t;

    // One divider stage word
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] dvd;
        logic [DIV_W-1:0] quot;
        tag_t             tag;
    } div_word_t;

    // One restoring-division step: bring down the next dividend bit
    function automatic div_word_t div_step(input div_word_t w, input logic [REM_W-1:0] d);
        div_word_t   r;
        logic [REM_W:0] sh;
        logic           ge;
        r  = w;
        sh = {w.rem, w.dvd[DIV_W-1]};
        ge = (sh >= {1'b0, d});
        r.dvd  = {w.dvd[DIV_W-2:0], 1'b0};
        r.quot = {w.quot[DIV_W-2:0], ge};
        r.rem  = ge ? REM_W'(sh - {1'b0, d}) : sh[REM_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/iexp_div.sv @@
`default_nettype none

module iexp_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [iexp_pkg::DIV_W-1:0]  in_dividend,
    input  wire iexp_pkg::tag_t              in_tag,
    input  wire logic [iexp_pkg::REM_W-1:0]  divisor,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [iexp_pkg::DIV_W-1:0]       out_quot,
    output logic [iexp_pkg::REM_W-1:0]       out_rem,
    output iexp_pkg::tag_t                   out_tag
);

    logic                        stg_valid_reg [iexp_pkg::DIV_STAGES];
    iexp_pkg::div_word_t         stg_word_reg  [iexp_pkg::DIV_STAGES];
    iexp_pkg::div_word_t         stg_word_next [iexp_pkg::DIV_STAGES];
    logic [iexp_pkg::DIV_STAGES:0] stg_ready;

    assign stg_ready[iexp_pkg::DIV_STAGES] = out_ready;
    assign in_ready = stg_ready[0];

    genvar gi;
    generate
        for (gi = 0; gi < iexp_pkg::DIV_STAGES; gi++)
        begin : g_stage
            iexp_pkg::div_word_t src;
            logic                src_valid;

            // Stage source: fresh word at the head, previous stage after that
            if (gi == 0)
            begin : g_head
                assign src_valid = in_valid;
                always_comb
                begin
                    src      = '0;
                    src.dvd  = in_dividend;
                    src.tag  = in_tag;
                end
            end
            else
            begin : g_body
                assign src_valid = stg_valid_reg[gi-1];
                assign src       = stg_word_reg[gi-1];
            end

            // Stage may load when empty or when its word moves on
            assign stg_ready[gi] = !stg_valid_reg[gi] || stg_ready[gi+1];

            // Quotient bits for this stage
            always_comb
            begin
                stg_word_next[gi] = src;
                for (int j = 0; j < iexp_pkg::DIV_STEPS; j++)
                begin
                    stg_word_next[gi] = iexp_pkg::div_step(stg_word_next[gi], divisor);
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    stg_valid_reg[gi] <= 1'b0;
                end
                else if (stg_ready[gi])
                begin
                    stg_valid_reg[gi] <= src_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (stg_ready[gi] && src_valid)
                begin
                    stg_word_reg[gi] <= stg_word_next[gi];
                end
            end
        end
    endgenerate

    assign out_valid = stg_valid_reg[iexp_pkg::DIV_STAGES-1];
    assign out_quot  = stg_word_reg[iexp_pkg::DIV_STAGES-1].quot;
    assign out_rem   = stg_word_reg[iexp_pkg::DIV_STAGES-1].rem;
    assign out_tag   = stg_word_reg[iexp_pkg::DIV_STAGES-1].tag;

endmodule

`default_nettype wire

@@ hdl/integer_exp_second_order_unit.sv @@
`default_nettype none

// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  logit [31:0], random_fraction [55:32]
// m_axis    out  m_axis_tvalid/m_axis_tready  exp_value [30:0], zero pad [31]
// cfg       in   cfg_valid/cfg_ready          cfg_index register number, cfg_data value
//
// One word per cycle sustained while m_axis_tready is high; from input accept to output,
// a word passes 16 divider stages at 2 quotient bits each, then the magnitude, square,
// offset/saturate and rounding/output registers.
// rst_n clears all stage valids and loads the config registers with their reset values.
// Each stage loads when empty or when its word moves on, so bubbles close up and a
// stall at m_axis backs up word by word without loss.
module integer_exp_second_order_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // logit [31:0], random_fraction [55:32]
    input  wire logic [iexp_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // exp_value [30:0], zero pad above
    output logic [iexp_pkg::M_TDATA_W-1:0]          m_axis_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [iexp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [31:0]                        cfg_data
);

    // Config registers
    logic signed [31:0] cfg_thresh_reg;
    logic [29:0]        cfg_ln2_reg;
    logic signed [15:0] cfg_b_reg;
    logic [29:0]        cfg_c_reg;
    logic [1:0]         cfg_mode_reg;
    logic [29:0]        divisor;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_thresh_reg <= 32'sh8000_0001;
            cfg_ln2_reg    <= 30'd1;
            cfg_b_reg      <= '0;
            cfg_c_reg      <= '0;
            cfg_mode_reg   <= iexp_pkg::RND_TRUNC;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                iexp_pkg::REG_THRESH: cfg_thresh_reg <= signed'(cfg_data);
                iexp_pkg::REG_LN2:    cfg_ln2_reg    <= cfg_data[29:0];
                iexp_pkg::REG_B:      cfg_b_reg      <= signed'(cfg_data[15:0]);
                iexp_pkg::REG_C:      cfg_c_reg      <= cfg_data[29:0];
                iexp_pkg::REG_MODE:   cfg_mode_reg   <= cfg_data[1:0];
                default:              ;
            endcase
        end
    end

    // A zero ln2 divides as one
    assign divisor = (cfg_ln2_reg == '0) ? 30'd1 : cfg_ln2_reg;

    // Input decode: underflow flag and magnitude of the clamped logit
    logic signed [31:0]  in_logit;
    logic [31:0]         in_mag;
    iexp_pkg::tag_t      in_tag;

    always_comb
    begin
        in_logit   = signed'(s_axis_tdata[31:0]);
        in_mag     = (in_logit > 0) ? 32'd0 : 32'(32'd0 - s_axis_tdata[31:0]);
        in_tag.zero = (in_logit <= cfg_thresh_reg);
        in_tag.rf   = s_axis_tdata[iexp_pkg::LOGIT_W +: iexp_pkg::RANDOM_BITS];
    end

    // Range reduction
    logic                       dv_valid;
    logic                       dv_ready;
    logic [31:0]                dv_quot;
    logic [29:0]                dv_rem;
    iexp_pkg::tag_t             dv_tag;

    iexp_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_dividend (in_mag),
        .in_tag      (in_tag),
        .divisor     (divisor),
        .out_valid   (dv_valid),
        .out_ready   (dv_ready),
        .out_quot    (dv_quot),
        .out_rem     (dv_rem),
        .out_tag     (dv_tag)
    );

    // Stage ready chain
    logic mg_ready, sq_ready, pl_ready, o_ready;
    logic mg_valid_reg, sq_valid_reg, pl_valid_reg, o_valid_reg;

    assign o_ready  = !o_valid_reg  || m_axis_tready;
    assign pl_ready = !pl_valid_reg || o_ready;
    assign sq_ready = !sq_valid_reg || pl_ready;
    assign mg_ready = !mg_valid_reg || sq_ready;
    assign dv_ready = mg_ready;

    // Magnitude stage: |b - rem|, shift amount
    logic [15:0]    mg_sq_in_reg,  mg_sq_in_next;
    logic           mg_big_reg,    mg_big_next;
    logic [4:0]     mg_k_reg,      mg_k_next;
    logic           mg_qzero_reg,  mg_qzero_next;
    iexp_pkg::tag_t mg_tag_reg;
    logic [33:0]    mg_t;
    logic [33:0]    mg_mag;

    always_comb
    begin
        mg_t          = 34'(cfg_b_reg) - {4'b0, dv_rem};
        mg_mag        = mg_t[33] ? 34'(34'd0 - mg_t) : mg_t;
        mg_big_next   = (mg_mag > iexp_pkg::SQRT_SAT);
        mg_sq_in_next = mg_mag[15:0];
        mg_k_next     = (dv_quot > 32'(iexp_pkg::MAX_SHIFT)) ? iexp_pkg::MAX_SHIFT
                                                              : dv_quot[4:0];
        mg_qzero_next = (dv_quot == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mg_valid_reg <= 1'b0;
        end
        else if (mg_ready)
        begin
            mg_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mg_ready && dv_valid)
        begin
            mg_sq_in_reg <= mg_sq_in_next;
            mg_big_reg   <= mg_big_next;
            mg_k_reg     <= mg_k_next;
            mg_qzero_reg <= mg_qzero_next;
            mg_tag_reg   <= dv_tag;
        end
    end

    // Square stage
    logic [31:0]    sq_sq_reg;
    logic           sq_big_reg;
    logic [4:0]     sq_k_reg;
    logic           sq_qzero_reg;
    iexp_pkg::tag_t sq_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
        end
        else if (sq_ready)
        begin
            sq_valid_reg <= mg_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_ready && mg_valid_reg)
        begin
            sq_sq_reg    <= 32'(mg_sq_in_reg) * 32'(mg_sq_in_reg);
            sq_big_reg   <= mg_big_reg;
            sq_k_reg     <= mg_k_reg;
            sq_qzero_reg <= mg_qzero_reg;
            sq_tag_reg   <= mg_tag_reg;
        end
    end

    // Offset and saturate stage
    logic [30:0]    pl_p_reg, pl_p_next;
    logic [4:0]     pl_k_reg;
    logic           pl_qzero_reg;
    iexp_pkg::tag_t pl_tag_reg;
    logic [32:0]    pl_sum;

    always_comb
    begin
        pl_sum    = {1'b0, sq_sq_reg} + {3'b0, cfg_c_reg};
        pl_p_next = (sq_big_reg || pl_sum > 33'(iexp_pkg::SAT31)) ? iexp_pkg::SAT31
                                                                  : pl_sum[30:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pl_valid_reg <= 1'b0;
        end
        else if (pl_ready)
        begin
            pl_valid_reg <= sq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pl_ready && sq_valid_reg)
        begin
            pl_p_reg     <= pl_p_next;
            pl_k_reg     <= sq_k_reg;
            pl_qzero_reg <= sq_qzero_reg;
            pl_tag_reg   <= sq_tag_reg;
        end
    end

    // Rounding shift into the output register
    localparam int DRAW_W = iexp_pkg::RANDOM_BITS + iexp_pkg::EXP_W;

    logic [30:0]       o_data_reg, o_data_next;
    logic [31:0]       rd_half;
    logic [30:0]       rd_mask;
    logic [30:0]       rd_rem;
    logic [DRAW_W-1:0] rd_wide;
    logic [30:0]       rd_draw;

    always_comb
    begin
        rd_half = ({1'b0, pl_p_reg} + (32'd1 << (pl_k_reg - 5'd1))) >> pl_k_reg;
        rd_mask = 31'((31'd1 << pl_k_reg) - 31'd1);
        rd_rem  = pl_p_reg & rd_mask;
        rd_wide = DRAW_W'(pl_tag_reg.rf) << pl_k_reg;
        rd_draw = rd_wide[DRAW_W-1:iexp_pkg::RANDOM_BITS];
        case (cfg_mode_reg)
            iexp_pkg::RND_TRUNC:
                o_data_next = pl_qzero_reg ? pl_p_reg : (pl_p_reg >> pl_k_reg);
            iexp_pkg::RND_HALF:
                o_data_next = pl_qzero_reg ? pl_p_reg : rd_half[30:0];
            iexp_pkg::RND_STOCH:
                o_data_next = pl_qzero_reg ? pl_p_reg
                            : (pl_p_reg >> pl_k_reg) + {30'b0, (rd_draw < rd_rem)};
            default:
                o_data_next = '0;
        endcase
        if (pl_tag_reg.zero)
        begin
            o_data_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_ready)
        begin
            o_valid_reg <= pl_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_ready && pl_valid_reg)
        begin
            o_data_reg <= o_data_next;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = iexp_pkg::M_TDATA_W'(o_data_reg);

    // Input backs up only when every stage up to the output is holding
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while output side can drain");

    // The unused rounding code yields zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && cfg_mode_reg != iexp_pkg::RND_TRUNC
            && cfg_mode_reg != iexp_pkg::RND_HALF
            && cfg_mode_reg != iexp_pkg::RND_STOCH) |-> (o_data_reg == '0))
        else $error("unused rounding mode gave a nonzero word");

    // An underflowed word leaving the saturate stage becomes zero at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        (pl_valid_reg && o_ready && pl_tag_reg.zero) |=> (o_data_reg == '0))
        else $error("underflow word not forced to zero");

endmodule

`default_nettype wire

@@ tb/tb_integer_exp_second_order_unit.sv @@
`timescale 1ns / 100ps

module tb_integer_exp_second_order_unit;

    localparam int LATENCY     = 20;
    localparam int SETTLE      = LATENCY + 10;
    localparam int CYCLE_LIMIT = 1000000;
    localparam longint unsigned SAT_LIMIT = 64'h7FFF_FFFF;
    localparam longint THR_FLOOR = -64'sd2147483647;

    // One input word: logit in the low bits, draw above it
    typedef struct packed {
        logic [iexp_pkg::RANDOM_BITS-1:0] frac;
        logic [iexp_pkg::LOGIT_W-1:0]     logit;
    } logit_word_t;

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // logit [31:0], random_fraction [55:32]
    logic [iexp_pkg::S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // exp_value [30:0], zero pad [31]
    logic [iexp_pkg::M_TDATA_W-1:0]  m_axis_tdata;
    logic                            cfg_valid     = 1'b0;
    logic                            cfg_ready;
    logic [iexp_pkg::CFG_IDX_W-1:0]  cfg_index     = iexp_pkg::REG_THRESH;
    logic [31:0]                     cfg_data      = '0;

    // Local copy of the register file
    logic signed [31:0]    thr_cfg  = -32'sd2147483647;
    logic [29:0]           ln2_cfg  = 30'd1;
    logic signed [15:0]    b_cfg    = '0;
    logic [29:0]           c_cfg    = '0;
    logic [1:0]            mode_cfg = iexp_pkg::RND_TRUNC;

    logit_word_t                 logit_queue[$];
    logic [iexp_pkg::EXP_W-1:0]  exp_due[$];
    logic [iexp_pkg::EXP_W-1:0]  exp_want;

    bit                    quiet     = 1'b1;
    bit                    send_hold = 1'b0;
    int                    send_gap  = 0;
    int                    recv_gap  = 0;
    int                    cycle_cnt = 0;
    int                    error_cnt = 0;
    int                    checked_cnt = 0;
    int                    settings_cnt = 0;
    int                    mode_cnt[4] = '{0, 0, 0, 0};

    integer_exp_second_order_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Expected exponential for one logit under the current registers
    function automatic logic [iexp_pkg::EXP_W-1:0] predict_exp(
        input logic [iexp_pkg::LOGIT_W-1:0]     logit_bits,
        input logic [iexp_pkg::RANDOM_BITS-1:0] frac);
        longint          q, r, t;
        longint unsigned unit, z, mag, p, rem, draw, res;
        int              k;
        q = longint'($signed(logit_bits));
        if (q <= longint'(thr_cfg))
            return '0;
        // out-of-range positive logit behaves as zero
        if (q > 0)
            q = 0;
        unit = (ln2_cfg == 0) ? 64'd1 : 64'(ln2_cfg);
        z    = $unsigned(-q) / unit;
        r    = q + longint'(z * unit);
        t    = r + longint'(b_cfg);
        mag  = (t < 0) ? $unsigned(-t) : $unsigned(t);
        p    = mag * mag + 64'(c_cfg);
        if (p > SAT_LIMIT)
            p = SAT_LIMIT;
        if (z == 0)
            res = (mode_cfg == iexp_pkg::RND_TRUNC || mode_cfg == iexp_pkg::RND_HALF
                   || mode_cfg == iexp_pkg::RND_STOCH) ? p : 64'd0;
        else
        begin
            k = (z > iexp_pkg::MAX_SHIFT) ? int'(iexp_pkg::MAX_SHIFT) : int'(z);
            case (mode_cfg)
                iexp_pkg::RND_TRUNC: res = p >> k;
                iexp_pkg::RND_HALF:  res = (p + (64'd1 << (k - 1))) >> k;
                iexp_pkg::RND_STOCH:
                begin
                    rem  = p & ((64'd1 << k) - 64'd1);
                    draw = (64'(frac) << k) >> iexp_pkg::RANDOM_BITS;
                    res  = (p >> k) + ((draw < rem) ? 64'd1 : 64'd0);
                end
                default:   res = 64'd0;
            endcase
        end
        return res[iexp_pkg::EXP_W-1:0];
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint clamp_thr(input longint v);
        if (v < THR_FLOOR)
            return THR_FLOOR;
        if (v > 0)
            return 0;
        return v;
    endfunction

    // Random logit, steered around ln2 multiples and the threshold
    function automatic logic [31:0] gen_logit();
        longint unsigned unit;
        longint          v;
        int              sel;
        unit = (ln2_cfg == 0) ? 64'd1 : 64'(ln2_cfg);
        sel  = $urandom_range(0, 99);
        if (sel < 40)
            v = -longint'(unit * $urandom_range(0, 40) + $urandom_range(0, 32'(unit - 1)));
        else if (sel < 50)
            v = -longint'(unit * $urandom_range(0, 40));
        else if (sel < 60)
            v = longint'(thr_cfg) + int'($urandom_range(0, 2)) - 1;
        else if (sel < 70)
            v = -int'($urandom_range(0, 64));
        else if (sel < 85)
            v = longint'($signed($urandom()));
        else
            v = -longint'($urandom_range(0, 32'h7FFF_FFFF));
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        return v[31:0];
    endfunction

    task automatic push_item(input logic [31:0] logit,
                             input logic [iexp_pkg::RANDOM_BITS-1:0] frac);
        logit_word_t w;
        w.logit = logit;
        w.frac  = frac;
        logit_queue.push_back(w);
    endtask

    task automatic push_random(input int n);
        repeat (n)
            push_item(gen_logit(), iexp_pkg::RANDOM_BITS'($urandom()));
    endtask

    task automatic write_reg(input logic [iexp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            iexp_pkg::REG_THRESH: thr_cfg  = val;
            iexp_pkg::REG_LN2:    ln2_cfg  = val[29:0];
            iexp_pkg::REG_B:      b_cfg    = val[15:0];
            iexp_pkg::REG_C:      c_cfg    = val[29:0];
            iexp_pkg::REG_MODE:   mode_cfg = val[1:0];
            default:    ;
        endcase
    endtask

    // Full register load; junk fills the bits above each field with random bits
    task automatic load_config(input longint thr, input logic [29:0] ln2,
                               input logic [15:0] b, input logic [29:0] c,
                               input logic [1:0] mode, input bit junk);
        logic [31:0] fill;
        fill = junk ? $urandom() : 32'd0;
        write_reg(iexp_pkg::REG_THRESH, 32'(thr));
        write_reg(iexp_pkg::REG_LN2,    {fill[31:30], ln2});
        write_reg(iexp_pkg::REG_B,      {fill[31:16], b});
        write_reg(iexp_pkg::REG_C,      {fill[31:30], c});
        write_reg(iexp_pkg::REG_MODE,   {fill[31:2], mode});
        settings_cnt++;
    endtask

    // Softmax-like coefficients: b ~ 1.353 ln2, c ~ 0.344 b^2
    task automatic load_typical(input logic [1:0] mode);
        longint unit, b;
        unit = $urandom_range(1000, 20000);
        b    = (unit * 1353) / 1000;
        load_config(-unit * 30, 30'(unit), 16'(b), 30'((b * b * 344) / 1000), mode, 1'b0);
    endtask

    task automatic load_random();
        logic [29:0] ln2;
        int          roll;
        roll = $urandom_range(0, 2);
        if (roll == 0)
            ln2 = 30'($urandom_range(1, 64));
        else if (roll == 1)
            ln2 = 30'($urandom_range(100, 50000));
        else
            ln2 = 30'($urandom_range(0, 32'h3FFF_FFFF));
        load_config(-longint'($urandom_range(0, 32'h7FFF_FFFF)), ln2,
                    16'($urandom_range(0, 65535)), 30'($urandom_range(0, 32'h3FFF_FFFF)),
                    2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endtask

    // Wait until every word is sent and checked, then let the pipe settle
    task automatic drain();
        do
            @(negedge clk);
        while (logit_queue.size() != 0 || s_axis_tvalid || exp_due.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic start_phase(input bit calm, input int n);
        @(negedge clk);
        quiet = calm;
        push_random(n);
    endtask

    // Input driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                exp_due.push_back(predict_exp(
                    s_axis_tdata[iexp_pkg::LOGIT_W-1:0],
                    s_axis_tdata[iexp_pkg::LOGIT_W +: iexp_pkg::RANDOM_BITS]));
                mode_cnt[mode_cfg]++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (logit_queue.size() > 0 && !send_hold)
                begin
                    s_axis_tdata  <= logit_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    send_gap = pick_gap();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output monitor and backpressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                checked_cnt++;
                if (exp_due.size() == 0)
                begin
                    $display("%0t: result word %h with nothing expected", $time, m_axis_tdata);
                    error_cnt++;
                end
                else
                begin
                    exp_want = exp_due.pop_front();
                    if (m_axis_tdata[iexp_pkg::EXP_W-1:0] !== exp_want)
                    begin
                        $display("%0t: exp_value expected %h actual %h",
                                 $time, exp_want, m_axis_tdata[iexp_pkg::EXP_W-1:0]);
                        error_cnt++;
                    end
                    if (m_axis_tdata[iexp_pkg::M_TDATA_W-1:iexp_pkg::EXP_W] !== '0)
                    begin
                        $display("%0t: pad bits expected 0 actual %h",
                                 $time, m_axis_tdata[iexp_pkg::M_TDATA_W-1:iexp_pkg::EXP_W]);
                        error_cnt++;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("%0t: no progress after %0d cycles", $time, cycle_cnt);
            $display("tb_integer_exp_second_order_unit: errors");
            $finish;
        end
    end

    // Stimulus sequence
    initial
    begin
        longint unit;
        longint thr;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Registers at reset values
        @(negedge clk);
        quiet = 1'b1;
        push_item(32'd0, '0);
        push_item(32'h8000_0000, '1);
        push_item(32'h8000_0001, '0);
        push_item(32'h7FFF_FFFF, '1);
        push_item(-32'sd5, '0);
        push_random(20);
        drain();

        // Typical coefficients, half-up rounding, corner logits
        load_typical(iexp_pkg::RND_HALF);
        @(negedge clk);
        quiet = 1'b0;
        unit  = ln2_cfg;
        thr   = thr_cfg;
        push_item(32'd0, '0);
        push_item(-32'sd1, '1);
        push_item(32'h8000_0000, '0);
        push_item(32'h8000_0001, '1);
        push_item(32'h7FFF_FFFF, '0);
        push_item(32'd1, '1);
        push_item(32'(thr), '0);
        push_item(32'(thr + 1), '1);
        push_item(32'(-unit), '0);
        push_item(32'(-unit + 1), '1);
        push_item(32'(-unit * 31), '0);
        push_item(32'(-unit * 29 - unit / 2), '1);
        push_item(32'(-unit * 29), '1);
        push_item(32'(-unit * 29), '0);
        push_random(200);
        drain();

        // Truncation, no idling on either side
        load_typical(iexp_pkg::RND_TRUNC);
        start_phase(1'b1, 200);
        drain();

        // Stochastic; halfway through the sender holds until the pipe is empty
        load_typical(iexp_pkg::RND_STOCH);
        start_phase(1'b0, 250);
        do
            @(negedge clk);
        while (logit_queue.size() > 125);
        send_hold = 1'b1;
        do
            @(negedge clk);
        while (s_axis_tvalid || exp_due.size() != 0);
        send_hold = 1'b0;
        drain();

        // Register extremes: saturation and the largest divisor
        load_config(THR_FLOOR, 30'h3FFF_FFFF, 16'h8000, 30'h3FFF_FFFF,
                    iexp_pkg::RND_STOCH, 1'b0);
        start_phase(1'b0, 150);
        drain();

        // Zero divisor, top threshold, largest positive offset
        load_config(0, 30'd0, 16'h7FFF, 30'd0, iexp_pkg::RND_HALF, 1'b0);
        start_phase(1'b0, 60);
        drain();

        // Unused rounding mode
        load_config(clamp_thr(-longint'($urandom_range(0, 32'h7FFF_FFFF))),
                    30'($urandom_range(1, 50000)), 16'($urandom_range(0, 65535)),
                    30'($urandom_range(0, 32'h3FFF_FFFF)), 2'd3, 1'b1);
        start_phase(1'b1, 60);
        drain();

        // Tiny divisor: shifts mostly past the cap
        load_config(-longint'($urandom_range(0, 32'h7FFF_FFFF)), 30'($urandom_range(1, 16)),
                    16'($urandom_range(0, 65535)), 30'($urandom_range(0, 32'h3FFF_FFFF)),
                    2'($urandom_range(0, 2)), 1'b1);
        start_phase(1'b0, 150);
        drain();

        // Fully random settings
        repeat (4)
        begin
            load_random();
            start_phase(1'($urandom_range(0, 3) == 0), 125);
            drain();
        end

        error_cnt += exp_due.size();
        $display("%0d result words checked over %0d register settings", checked_cnt,
                 settings_cnt);
        $display("words per rounding mode: trunc %0d, half %0d, stoch %0d, unused %0d",
                 mode_cnt[0], mode_cnt[1], mode_cnt[2], mode_cnt[3]);
        if (error_cnt == 0)
            $display("tb_integer_exp_second_order_unit: clean");
        else
            $display("tb_integer_exp_second_order_unit: errors");
        $finish;
    end

endmodule

@@ integer_exp_second_order_unit.f @@
hdl/iexp_pkg.sv
hdl/iexp_div.sv
hdl/integer_exp_second_order_unit.sv
tb/tb_integer_exp_second_order_unit.sv
